### rtl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg
// Types and constants shared by the traffic window statistics block.
// ----------------------------------------------------------------------------
package tws_pkg;

    localparam int TS_W     = 40;   // timestamp width
    localparam int LOG_W    = 20;   // log2 value, 4 integer and 16 fraction bits
    localparam int LOG_FRAC = 16;

    localparam logic [16:0] RATIO_MAX   = 17'd65536;
    localparam logic [19:0] ENTROPY_MAX = 20'd655360;

    typedef struct packed {
        logic            is_write;
        logic [7:0]      function_code;
        logic [15:0]     address;
        logic [3:0]      protocol_id;
        logic [TS_W-1:0] timestamp;
        logic            last;
    } t_rec;

    typedef struct packed {
        logic [10:0] record_count;
        logic [16:0] write_ratio;
        logic [16:0] function_concentration;
        logic [19:0] address_entropy;
        logic [16:0] protocol_dominance;
        logic [31:0] mean_interarrival;
        logic [31:0] std_interarrival;
        logic [16:0] target_density;
        logic        window_overflow;
    } t_res;

endpackage

### rtl/tws_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_if
// Valid/ready channels carrying traffic records and window results.
// ----------------------------------------------------------------------------
interface tws_rec_if;
    logic          valid;
    logic          ready;
    tws_pkg::t_rec data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tws_res_if;
    logic          valid;
    logic          ready;
    tws_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/traffic_window_statistics.sv
`timescale 1ns / 1ps
// A record passes the read, write back and accumulate steps; the block takes no new record
// until the last is through. A last record then starts the close: per distinct address a list
// read, a histogram read and a 16-step log2 loop, then ~2*(DELTA_BITS+11) multiply steps, 7
// divisions on the shared restoring divider, the square root loop and a clear sweep over
// max(FUNCTION_CODES, PROTOCOL_IDS) entries. Reset: after i_rst_n rises the block sweeps all
// histogram memories over 2**ADDRESS_BITS addresses before it takes the first record.
// ----------------------------------------------------------------------------
// traffic_window_statistics
// Histogram-based statistics over windows of traffic records.
// ----------------------------------------------------------------------------
module traffic_window_statistics #(
    parameter int WINDOW_MAX     = 1024,
    parameter int ADDRESS_BITS   = 16,
    parameter int FUNCTION_CODES = 256,
    parameter int PROTOCOL_IDS   = 16,
    parameter int DELTA_BITS     = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tws_rec_if.sink   i_rec,
    tws_res_if.source o_res
);

    localparam int CW     = $clog2(WINDOW_MAX + 1);
    localparam int TW     = $clog2(WINDOW_MAX);
    localparam int FW     = $clog2(FUNCTION_CODES);
    localparam int PW     = $clog2(PROTOCOL_IDS);
    localparam int AB     = ADDRESS_BITS;
    localparam int IW     = ((AB > CW) ? AB : CW) + 1;
    localparam int SUM_W  = DELTA_BITS + CW;
    localparam int SQ_W   = 2 * DELTA_BITS + CW;
    localparam int DN_W   = 2 * SUM_W;
    localparam int DIV_NW = DN_W + 16;
    localparam int DIV_DW = 2 * CW;
    localparam int ISQ_W  = 2 * DELTA_BITS + 16;
    localparam int S_W    = 2 * CW + tws_pkg::LOG_W;
    localparam int CLR_N  = (FUNCTION_CODES > PROTOCOL_IDS) ? FUNCTION_CODES : PROTOCOL_IDS;
    localparam int MCW    = $clog2(SUM_W + 1);
    localparam int DCW    = $clog2(DIV_NW + 1);
    localparam int SCW    = $clog2(ISQ_W / 2 + 1);

    localparam logic [IW-1:0] INIT_LAST = IW'((1 << AB) - 1);
    localparam logic [IW-1:0] CLR_LAST  = IW'(CLR_N - 1);
    localparam logic [IW-1:0] FC_LIM    = IW'(FUNCTION_CODES);
    localparam logic [IW-1:0] PR_LIM    = IW'(PROTOCOL_IDS);
    localparam logic [CW-1:0] WIN_LIM   = CW'(WINDOW_MAX);
    localparam logic [tws_pkg::TS_W-1:0] DMAX =
        (tws_pkg::TS_W'(1) << DELTA_BITS) - tws_pkg::TS_W'(1);
    localparam logic [ISQ_W-1:0] SBIT_INIT = ISQ_W'(1) << (ISQ_W - 2);

    // code wrap tables
    function automatic logic [256*FW-1:0] fc_table();
        logic [256*FW-1:0] t;
        t = '0;
        for (int i = 0; i < 256; i++) begin
            t[i*FW +: FW] = FW'(i % FUNCTION_CODES);
        end
        return t;
    endfunction

    function automatic logic [16*PW-1:0] pr_table();
        logic [16*PW-1:0] t;
        t = '0;
        for (int i = 0; i < 16; i++) begin
            t[i*PW +: PW] = PW'(i % PROTOCOL_IDS);
        end
        return t;
    endfunction

    localparam logic [256*FW-1:0] FC_TAB = fc_table();
    localparam logic [16*PW-1:0]  PR_TAB = pr_table();

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_UPD, S_ACC,
        S_W_T, S_W_A, S_W_C, S_W_M,
        S_L0, S_L1,
        S_M0, S_M1,
        S_D0, S_D1, S_D2,
        S_Q1, S_CLR, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        D_WR, D_MF, D_MP, D_MA, D_ENT, D_MEAN, D_STD
    } t_dsel;

    t_state r_state;
    t_dsel  r_dsel;

    // memories
    logic [CW-1:0] fn_mem [FUNCTION_CODES];
    logic [CW-1:0] pr_mem [PROTOCOL_IDS];
    logic [CW-1:0] ad_mem [1 << AB];
    logic [AB-1:0] tt_mem [WINDOW_MAX];

    logic [CW-1:0] fn_q, pr_q, ad_q;
    logic [AB-1:0] tt_q;

    logic          fn_we, pr_we, ad_we, tt_we;
    logic [FW-1:0] fn_wa, fn_ra;
    logic [PW-1:0] pr_wa, pr_ra;
    logic [AB-1:0] ad_wa, ad_ra;
    logic [TW-1:0] tt_wa, tt_ra;
    logic [CW-1:0] fn_wd, pr_wd, ad_wd;

    // record latch
    logic                     r_iswr, r_last, r_counted;
    logic [tws_pkg::TS_W-1:0] r_ts;
    logic [FW-1:0]            r_fc;
    logic [PW-1:0]            r_pr;
    logic [AB-1:0]            r_ad;

    // window state
    logic [CW-1:0]            r_n, r_wr, r_mf, r_mp, r_ma, r_dist;
    logic [tws_pkg::TS_W-1:0] r_prev;
    logic [SUM_W-1:0]         r_dsum;
    logic [SQ_W-1:0]          r_dsq;
    logic [DELTA_BITS-1:0]    r_delta;
    logic                     r_has_delta, r_ovf;

    logic [IW-1:0] r_idx;
    logic [AB-1:0] r_tad;

    // log2 loop
    logic [CW-1:0]                  r_lc;
    logic [3:0]                     r_lk;
    logic [30:0]                    r_lm;
    logic [tws_pkg::LOG_FRAC-1:0]   r_lfrac;
    logic [3:0]                     r_lcnt;
    logic                           r_lfor_n;
    logic [S_W-1:0]                 r_slog;
    logic [tws_pkg::LOG_W-1:0]      r_lgn;

    // shift-add multiplier
    logic [DN_W-1:0]  r_mpa, r_mpp, r_aprod, r_dn;
    logic [SUM_W-1:0] r_mpb;
    logic [MCW-1:0]   r_mcnt;
    logic             r_msel;
    logic [DIV_DW-1:0] r_mm;

    // divider
    logic [DIV_NW-1:0] r_dnum;
    logic [DIV_DW-1:0] r_drem, r_dden;
    logic [DCW-1:0]    r_dcnt;

    // square root
    logic [ISQ_W-1:0] r_sx, r_sres, r_sbit;
    logic [SCW-1:0]   r_scnt;

    // results
    logic [16:0] r_q_wr, r_q_mf, r_q_mp, r_q_ma;
    logic [19:0] r_q_ent;
    logic [31:0] r_q_mean;

    tws_pkg::t_res r_out;
    logic          r_o_valid;

    logic accept;
    assign i_rec.ready = (r_state == S_IDLE);
    assign accept      = i_rec.valid && i_rec.ready;
    assign o_res.valid = r_o_valid;
    assign o_res.data  = r_out;

    // combinational helpers
    logic [CW-1:0]            w_m;
    logic [CW-1:0]            fn_inc, pr_inc, ad_inc;
    logic [tws_pkg::TS_W-1:0] w_diff;
    logic [2*DELTA_BITS-1:0]  w_dsq;
    logic [3:0]               w_lk;
    logic [30:0]              w_lm0;
    logic [61:0]              w_lsq;
    logic [31:0]              w_lm2;
    logic [30:0]              n_lm;
    logic [tws_pkg::LOG_W-1:0] w_lval;
    logic [CW+tws_pkg::LOG_W-1:0] w_clog;
    logic [DN_W-1:0]          n_mpp;
    logic [DIV_DW:0]          w_trial;
    logic                     w_ge;
    logic [DIV_DW-1:0]        n_drem;
    logic [DIV_NW-1:0]        w_dq;
    logic [ISQ_W:0]           w_ssum;

    assign w_m    = r_n - CW'(1);
    assign fn_inc = fn_q + CW'(1);
    assign pr_inc = pr_q + CW'(1);
    assign ad_inc = ad_q + CW'(1);
    assign w_diff = (r_ts > r_prev) ? r_ts - r_prev : '0;
    assign w_dsq  = r_delta * r_delta;

    always_comb begin
        w_lk = '0;
        for (int b = 0; b < CW; b++) begin
            if (r_lc[b]) begin
                w_lk = 4'(b);
            end
        end
    end

    assign w_lm0  = 31'(r_lc) << (5'd30 - {1'b0, w_lk});
    assign w_lsq  = r_lm * r_lm;
    assign w_lm2  = w_lsq[61:30];
    assign n_lm   = w_lm2[31] ? w_lm2[31:1] : w_lm2[30:0];
    assign w_lval = {r_lk, r_lfrac};
    assign w_clog = r_lc * w_lval;

    assign n_mpp   = r_mpb[0] ? r_mpp + r_mpa : r_mpp;
    assign w_trial = {r_drem, r_dnum[DIV_NW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dden});
    assign n_drem  = w_ge ? DIV_DW'(w_trial - {1'b0, r_dden}) : DIV_DW'(w_trial);
    assign w_dq    = (r_dden == '0) ? '0 : r_dnum;
    assign w_ssum  = {1'b0, r_sres} + {1'b0, r_sbit};

    // memory port control
    always_comb begin
        fn_we = 1'b0;
        pr_we = 1'b0;
        ad_we = 1'b0;
        tt_we = 1'b0;
        fn_wa = r_fc;
        pr_wa = r_pr;
        ad_wa = r_ad;
        tt_wa = r_dist[TW-1:0];
        fn_wd = fn_inc;
        pr_wd = pr_inc;
        ad_wd = ad_inc;
        fn_ra = FC_TAB[i_rec.data.function_code*FW +: FW];
        pr_ra = PR_TAB[i_rec.data.protocol_id*PW +: PW];
        ad_ra = (r_state == S_W_A) ? tt_q : i_rec.data.address[AB-1:0];
        tt_ra = r_idx[TW-1:0];
        unique case (r_state)
            S_UPD: begin
                fn_we = r_counted;
                pr_we = r_counted;
                ad_we = r_counted;
                tt_we = r_counted && (ad_q == '0) && (r_dist < WIN_LIM);
            end
            S_W_C: begin
                ad_we = 1'b1;
                ad_wa = r_tad;
                ad_wd = '0;
            end
            S_INIT, S_CLR: begin
                fn_we = (r_idx < FC_LIM);
                pr_we = (r_idx < PR_LIM);
                ad_we = (r_state == S_INIT);
                fn_wa = r_idx[FW-1:0];
                pr_wa = r_idx[PW-1:0];
                ad_wa = r_idx[AB-1:0];
                fn_wd = '0;
                pr_wd = '0;
                ad_wd = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fn_we) begin
            fn_mem[fn_wa] <= fn_wd;
        end
        fn_q <= fn_mem[fn_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pr_we) begin
            pr_mem[pr_wa] <= pr_wd;
        end
        pr_q <= pr_mem[pr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ad_we) begin
            ad_mem[ad_wa] <= ad_wd;
        end
        ad_q <= ad_mem[ad_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tt_we) begin
            tt_mem[tt_wa] <= r_ad;
        end
        tt_q <= tt_mem[tt_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_dsel      <= D_WR;
            r_idx       <= '0;
            r_o_valid   <= 1'b0;
            r_n         <= '0;
            r_wr        <= '0;
            r_mf        <= '0;
            r_mp        <= '0;
            r_ma        <= '0;
            r_dist      <= '0;
            r_prev      <= '0;
            r_dsum      <= '0;
            r_dsq       <= '0;
            r_has_delta <= 1'b0;
            r_ovf       <= 1'b0;
            r_slog      <= '0;
        end else begin
            if (r_o_valid && o_res.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == INIT_LAST) begin
                        r_idx   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_iswr    <= i_rec.data.is_write;
                        r_last    <= i_rec.data.last;
                        r_ts      <= i_rec.data.timestamp;
                        r_fc      <= fn_ra;
                        r_pr      <= pr_ra;
                        r_ad      <= i_rec.data.address[AB-1:0];
                        r_counted <= (r_n < WIN_LIM);
                        r_state   <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_has_delta <= 1'b0;
                    if (r_counted) begin
                        r_n  <= r_n + CW'(1);
                        r_wr <= r_wr + CW'(r_iswr);
                        if (fn_inc > r_mf) begin
                            r_mf <= fn_inc;
                        end
                        if (pr_inc > r_mp) begin
                            r_mp <= pr_inc;
                        end
                        if (ad_inc > r_ma) begin
                            r_ma <= ad_inc;
                        end
                        if (tt_we) begin
                            r_dist <= r_dist + CW'(1);
                        end
                        if (r_n != '0) begin
                            r_has_delta <= 1'b1;
                            r_delta <= (w_diff > DMAX) ? DMAX[DELTA_BITS-1:0]
                                                       : w_diff[DELTA_BITS-1:0];
                        end
                        r_prev <= r_ts;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_has_delta) begin
                        r_dsum <= r_dsum + SUM_W'(r_delta);
                        r_dsq  <= r_dsq + SQ_W'(w_dsq);
                    end
                    r_idx   <= '0;
                    r_slog  <= '0;
                    r_state <= r_last ? S_W_T : S_IDLE;
                end
                // walk of the touched address list
                S_W_T: begin
                    if (r_idx < IW'(r_dist)) begin
                        r_state <= S_W_A;
                    end else begin
                        r_lc     <= r_n;
                        r_lfor_n <= 1'b1;
                        r_state  <= S_L0;
                    end
                end
                S_W_A: begin
                    r_tad   <= tt_q;
                    r_state <= S_W_C;
                end
                S_W_C: begin
                    r_lc     <= ad_q;
                    r_lfor_n <= 1'b0;
                    r_state  <= S_L0;
                end
                S_W_M: begin
                    r_slog  <= r_slog + S_W'(w_clog);
                    r_idx   <= r_idx + IW'(1);
                    r_state <= S_W_T;
                end
                // log2 by repeated squaring, one fraction bit per cycle
                S_L0: begin
                    r_lk    <= w_lk;
                    r_lm    <= w_lm0;
                    r_lfrac <= '0;
                    r_lcnt  <= '0;
                    r_state <= S_L1;
                end
                S_L1: begin
                    r_lm    <= n_lm;
                    r_lfrac <= {r_lfrac[tws_pkg::LOG_FRAC-2:0], w_lm2[31]};
                    r_lcnt  <= r_lcnt + 4'd1;
                    if (r_lcnt == 4'd15) begin
                        r_state <= r_lfor_n ? S_M0 : S_W_M;
                    end
                end
                S_M0: begin
                    r_lgn   <= w_lval;
                    r_mpa   <= DN_W'(r_dsq);
                    r_mpb   <= SUM_W'(w_m);
                    r_mpp   <= '0;
                    r_mcnt  <= '0;
                    r_msel  <= 1'b0;
                    r_mm    <= w_m * w_m;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_mpa  <= r_mpa << 1;
                    r_mpb  <= r_mpb >> 1;
                    r_mpp  <= n_mpp;
                    r_mcnt <= r_mcnt + MCW'(1);
                    if (r_mcnt == MCW'(SUM_W - 1)) begin
                        r_mcnt <= '0;
                        if (!r_msel) begin
                            r_aprod <= n_mpp;
                            r_mpa   <= DN_W'(r_dsum);
                            r_mpb   <= r_dsum;
                            r_mpp   <= '0;
                            r_msel  <= 1'b1;
                        end else begin
                            r_dn    <= (r_aprod < n_mpp) ? '0 : r_aprod - n_mpp;
                            r_dsel  <= D_WR;
                            r_state <= S_D0;
                        end
                    end
                end
                S_D0: begin
                    r_drem <= '0;
                    r_dcnt <= '0;
                    r_dden <= DIV_DW'(r_n);
                    unique case (r_dsel)
                        D_WR:   r_dnum <= DIV_NW'({r_wr, 16'd0});
                        D_MF:   r_dnum <= DIV_NW'({r_mf, 16'd0});
                        D_MP:   r_dnum <= DIV_NW'({r_mp, 16'd0});
                        D_MA:   r_dnum <= DIV_NW'({r_ma, 16'd0});
                        D_ENT:  r_dnum <= DIV_NW'(r_slog);
                        D_MEAN: begin
                            r_dnum <= DIV_NW'({r_dsum, 8'd0});
                            r_dden <= DIV_DW'(w_m);
                        end
                        D_STD: begin
                            r_dnum <= {r_dn, 16'd0};
                            r_dden <= r_mm;
                        end
                        default: r_dnum <= '0;
                    endcase
                    r_state <= S_D1;
                end
                S_D1: begin
                    r_drem <= n_drem;
                    r_dnum <= {r_dnum[DIV_NW-2:0], w_ge};
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(DIV_NW - 1)) begin
                        r_state <= S_D2;
                    end
                end
                S_D2: begin
                    r_state <= S_D0;
                    unique case (r_dsel)
                        D_WR:   begin r_q_wr <= 17'(w_dq); r_dsel <= D_MF; end
                        D_MF:   begin r_q_mf <= 17'(w_dq); r_dsel <= D_MP; end
                        D_MP:   begin r_q_mp <= 17'(w_dq); r_dsel <= D_MA; end
                        D_MA:   begin r_q_ma <= 17'(w_dq); r_dsel <= D_ENT; end
                        D_ENT: begin
                            r_q_ent <= r_lgn - 20'(w_dq);
                            r_dsel  <= D_MEAN;
                        end
                        D_MEAN: begin
                            r_q_mean <= 32'(w_dq);
                            r_dsel   <= D_STD;
                        end
                        D_STD: begin
                            r_sx    <= w_dq[ISQ_W-1:0];
                            r_sres  <= '0;
                            r_sbit  <= SBIT_INIT;
                            r_scnt  <= '0;
                            r_state <= S_Q1;
                        end
                        default: r_dsel <= D_WR;
                    endcase
                end
                // bit-pair square root
                S_Q1: begin
                    if ({1'b0, r_sx} >= w_ssum) begin
                        r_sx   <= ISQ_W'({1'b0, r_sx} - w_ssum);
                        r_sres <= (r_sres >> 1) + r_sbit;
                    end else begin
                        r_sres <= r_sres >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_scnt <= r_scnt + SCW'(1);
                    if (r_scnt == SCW'(ISQ_W / 2 - 1)) begin
                        r_idx   <= '0;
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + IW'(1);
                    if (r_idx == CLR_LAST) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_res.ready) begin
                        r_out.record_count           <= 11'(r_n);
                        r_out.write_ratio            <= r_q_wr;
                        r_out.function_concentration <= r_q_mf;
                        r_out.address_entropy        <= r_q_ent;
                        r_out.protocol_dominance     <= r_q_mp;
                        r_out.mean_interarrival      <= r_q_mean;
                        r_out.std_interarrival       <= 32'(r_sres);
                        r_out.target_density         <= r_q_ma;
                        r_out.window_overflow        <= r_ovf;
                        r_o_valid   <= 1'b1;
                        r_n         <= '0;
                        r_wr        <= '0;
                        r_mf        <= '0;
                        r_mp        <= '0;
                        r_ma        <= '0;
                        r_dist      <= '0;
                        r_prev      <= '0;
                        r_dsum      <= '0;
                        r_dsq       <= '0;
                        r_ovf       <= 1'b0;
                        r_has_delta <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/tws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_checker
// Port-level checks for the traffic window statistics block.
// ----------------------------------------------------------------------------
module tws_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input tws_pkg::t_res i_out_data
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a result never rises in the cycle after a record is taken
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result rose directly after a record");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_data.record_count != '0)
            && (i_out_data.write_ratio <= tws_pkg::RATIO_MAX)
            && (i_out_data.function_concentration <= tws_pkg::RATIO_MAX)
            && (i_out_data.protocol_dominance <= tws_pkg::RATIO_MAX)
            && (i_out_data.target_density <= tws_pkg::RATIO_MAX)
            && (i_out_data.address_entropy <= tws_pkg::ENTROPY_MAX))
        else $error("result field out of range");

endmodule

bind traffic_window_statistics tws_checker u_tws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_rec.valid),
    .i_in_ready  (i_rec.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

### tb/sv/tws_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_monitor
// Watches the record and result channels and keeps its own running
// statistics of the current window. Every result transaction is checked,
// field by field, against the oldest predicted window result.
// ----------------------------------------------------------------------------
module tws_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    tws_rec_if   rec,
    tws_res_if   res,
    output int   o_errors,
    output int   o_pending,
    output int   o_windows
);

    localparam int WIN_LIMIT  = 1024;
    localparam longint unsigned DELTA_CLAMP = (64'd1 << 24) - 1;

    tws_pkg::t_res win_q[$];

    int unsigned     fc_hist [256];
    int unsigned     proto_hist [16];
    int unsigned     addr_hist [int unsigned];
    int unsigned     n_rec, n_wr, max_fc, max_proto, max_addr;
    longint unsigned log_sum, prev_ts, d_sum, d_sq_sum;
    bit              dropped;

    function automatic longint unsigned log2_q16(longint unsigned c);
        longint unsigned k, mm, frac;
        k    = 0;
        frac = 0;
        if (c == 0) return 0;
        while (k < 30 && (c >> (k + 1)) != 0) k++;
        mm = c << (30 - k);
        for (int i = 0; i < 16; i++) begin
            mm   = (mm * mm) >> 30;
            frac = frac << 1;
            if (mm >= (64'd1 << 31)) begin
                frac = frac | 1;
                mm   = mm >> 1;
            end
        end
        return (k << 16) | frac;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned q16(longint unsigned x, longint unsigned n);
        return (n == 0) ? 0 : (x << 16) / n;
    endfunction

    function automatic void clear_window();
        foreach (fc_hist[i]) fc_hist[i] = 0;
        foreach (proto_hist[i]) proto_hist[i] = 0;
        addr_hist.delete();
        n_rec = 0; n_wr = 0; max_fc = 0; max_proto = 0; max_addr = 0;
        log_sum = 0; prev_ts = 0; d_sum = 0; d_sq_sum = 0; dropped = 0;
    endfunction

    function automatic void take_record(tws_pkg::t_rec r);
        longint unsigned d, c, n, m, lg, ts;
        logic [127:0]    a, b, dn;
        tws_pkg::t_res   e;
        ts = 64'(r.timestamp);
        if (n_rec < WIN_LIMIT) begin
            if (n_rec > 0) begin
                d = (ts > prev_ts) ? ts - prev_ts : 64'd0;
                if (d > DELTA_CLAMP) d = DELTA_CLAMP;
                d_sum    += d;
                d_sq_sum += d * d;
            end
            prev_ts = ts;
            n_rec++;
            if (r.is_write) n_wr++;
            fc_hist[r.function_code]++;
            if (fc_hist[r.function_code] > max_fc) max_fc = fc_hist[r.function_code];
            proto_hist[r.protocol_id]++;
            if (proto_hist[r.protocol_id] > max_proto) max_proto = proto_hist[r.protocol_id];
            c = addr_hist.exists(r.address) ? 64'(addr_hist[r.address]) : 64'd0;
            log_sum += (c + 1) * log2_q16(c + 1) - c * log2_q16(c);
            addr_hist[r.address] = 32'(c + 1);
            if (c + 1 > max_addr) max_addr = 32'(c + 1);
        end else begin
            dropped = 1;
        end
        if (!r.last) return;

        n  = n_rec;
        lg = log2_q16(n);
        e  = '0;
        e.record_count           = n[10:0];
        e.write_ratio            = 17'(q16(n_wr, n));
        e.function_concentration = 17'(q16(max_fc, n));
        e.address_entropy        = 20'(lg - log_sum / n);
        e.protocol_dominance     = 17'(q16(max_proto, n));
        e.target_density         = 17'(q16(max_addr, n));
        e.window_overflow        = dropped;
        if (n > 1) begin
            m  = n - 1;
            e.mean_interarrival = 32'((d_sum << 8) / m);
            a  = 128'(m) * 128'(d_sq_sum);
            b  = 128'(d_sum) * 128'(d_sum);
            dn = (a < b) ? '0 : a - b;
            dn = dn << 16;
            dn = dn / 128'(m * m);
            e.std_interarrival = 32'(isqrt(dn[63:0]));
        end
        win_q.insert(win_q.size(), e);
        clear_window();
    endfunction

    function automatic void cmp(string nm, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            o_errors++;
            if (o_errors <= 10)
                $display("mismatch window %0d %s: expected %0d got %0d",
                         o_windows, nm, exp_v, act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        tws_pkg::t_res e, g;
        if (!i_rst_n) begin
            win_q.delete();
            clear_window();
        end else begin
            if (res.valid && res.ready) begin
                g = res.data;
                if (win_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result transaction");
                end else begin
                    e = win_q.pop_front();
                    cmp("record_count", 32'(e.record_count), 32'(g.record_count));
                    cmp("write_ratio", 32'(e.write_ratio), 32'(g.write_ratio));
                    cmp("function_concentration", 32'(e.function_concentration),
                        32'(g.function_concentration));
                    cmp("address_entropy", 32'(e.address_entropy),
                        32'(g.address_entropy));
                    cmp("protocol_dominance", 32'(e.protocol_dominance),
                        32'(g.protocol_dominance));
                    cmp("mean_interarrival", e.mean_interarrival, g.mean_interarrival);
                    cmp("std_interarrival", e.std_interarrival, g.std_interarrival);
                    cmp("target_density", 32'(e.target_density), 32'(g.target_density));
                    cmp("window_overflow", 32'(e.window_overflow),
                        32'(g.window_overflow));
                end
                o_windows++;
            end
            if (rec.valid && rec.ready) take_record(rec.data);
        end
        o_pending = win_q.size();
    end

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_windows = 0;
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Traffic window statistics testbench: a directed set of windows on field
// extremes, timestamp wrap-back, delta clamping and window overflow, then
// random windows with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint LIMIT = 10000000;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, windows;
    int   n_sent;
    bit   hold_req;
    bit   idle_off;
    longint cycles;
    logic [tws_pkg::TS_W-1:0] ts_now;

    tws_rec_if rec_ch ();
    tws_res_if res_ch ();

    traffic_window_statistics dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (rec_ch.sink),
        .o_res   (res_ch.source)
    );

    tws_monitor chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .rec       (rec_ch),
        .res       (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_windows (windows)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (idle_off || p < 65) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // result side: random ready, plus one long hold-off on request
    initial begin
        int g;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (4000) @(posedge i_clk);
                hold_req = 0;
            end
            g = gap_len();
            if (g > 0) begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send(tws_pkg::t_rec r);
        int g;
        g = gap_len();
        if (g > 0) begin
            rec_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        rec_ch.valid <= 1'b1;
        rec_ch.data  <= r;
        do @(posedge i_clk); while (!rec_ch.ready);
        n_sent++;
    endtask

    function automatic tws_pkg::t_rec rand_rec(bit last, int addr_pool);
        tws_pkg::t_rec r;
        int            p;
        r.is_write      = 1'($urandom_range(1));
        r.function_code = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(3));
        r.address       = (addr_pool > 0) ? 16'($urandom_range(addr_pool - 1))
                                          : 16'($urandom_range(65535));
        r.protocol_id   = ($urandom_range(1)) ? 4'($urandom_range(15)) : 4'd2;
        p = $urandom_range(99);
        if (p < 80)      ts_now = ts_now + tws_pkg::TS_W'($urandom_range(2000));
        else if (p < 88) ts_now = ts_now + {8'($urandom_range(255)), $urandom()};
        else if (p < 95) ts_now = ts_now - tws_pkg::TS_W'($urandom_range(500));
        else             ts_now = {8'($urandom_range(255)), $urandom()};
        r.timestamp = ts_now;
        r.last      = last;
        return r;
    endfunction

    task automatic send_window(int len, int addr_pool);
        for (int i = 0; i < len; i++) send(rand_rec(i == len - 1, addr_pool));
    endtask

    function automatic tws_pkg::t_rec mk(bit w, logic [7:0] fc, logic [15:0] ad,
                                         logic [3:0] pr,
                                         logic [tws_pkg::TS_W-1:0] ts, bit last);
        tws_pkg::t_rec r;
        r.is_write = w; r.function_code = fc; r.address = ad;
        r.protocol_id = pr; r.timestamp = ts; r.last = last;
        return r;
    endfunction

    initial begin
        int len;
        cycles       = 0;
        n_sent       = 0;
        hold_req     = 0;
        idle_off     = 0;
        ts_now       = '0;
        i_rst_n      = 1'b0;
        rec_ch.valid = 1'b0;
        rec_ch.data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-record windows at the field extremes
        send(mk(1, 8'hFF, 16'hFFFF, 4'hF, {tws_pkg::TS_W{1'b1}}, 1));
        send(mk(0, 8'h00, 16'h0000, 4'h0, '0, 1));
        // same target, decreasing timestamp, then a jump that clamps
        send(mk(1, 8'h05, 16'h1234, 4'h3, 40'd1000, 0));
        send(mk(0, 8'h05, 16'h1234, 4'h3, 40'd900, 0));
        send(mk(1, 8'h05, 16'h1234, 4'h3, 40'hFF_FFFF_0000, 0));
        send(mk(1, 8'h07, 16'h1234, 4'h4, 40'hFF_FFFF_0010, 1));
        // all distinct, steady spacing
        for (int i = 0; i < 6; i++)
            send(mk(i[0], 8'(i * 40), 16'(i * 9000), 4'(i * 3), 40'(5000 + i * 77), i == 5));
        // mixed repeats, protocol tie, zero deltas
        for (int i = 0; i < 8; i++)
            send(mk(1, 8'h10, 16'(i % 3), 4'(i % 2), 40'd42, i == 7));

        // long window past the record limit, closed by a dropped record
        idle_off = 1;
        send_window(1030, 600);
        idle_off = 0;

        // let the long window drain, then pile up results while the receiver holds off
        rec_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        hold_req = 1;
        for (int i = 0; i < 40; i++) send(rand_rec(1, 4));

        while (n_sent < 1280) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            idle_off = ($urandom_range(7) == 0);
            send_window(len, ($urandom_range(2) == 0) ? 0 : $urandom_range(16, 1));
        end
        idle_off = 0;
        rec_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("%0d records sent, %0d window results checked", n_sent, windows);
        $display("covered: field extremes, clamped and negative deltas, overflow, backpressure");
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
